// File: rtl/acm_pkg.sv
// Package for the 12-bit accumulator machine: field widths, operation and
// opcode codes, and the memory request struct.
// No dependencies.
`default_nettype none

package acm_pkg;

  localparam int ADDR_W = 8;
  localparam int WORD_W = 12;
  localparam int OPER_W = 2;
  localparam int OPC_W  = 4;

  localparam logic [OPER_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OPER_W-1:0] OP_EXEC  = 2'd1;
  localparam logic [OPER_W-1:0] OP_READ  = 2'd2;

  localparam logic [OPC_W-1:0] OPC_FAULT = 4'd0;
  localparam logic [OPC_W-1:0] OPC_LOAD  = 4'd1;
  localparam logic [OPC_W-1:0] OPC_STORE = 4'd2;
  localparam logic [OPC_W-1:0] OPC_ADD   = 4'd3;
  localparam logic [OPC_W-1:0] OPC_SUB   = 4'd4;
  localparam logic [OPC_W-1:0] OPC_COPY  = 4'd5;
  localparam logic [OPC_W-1:0] OPC_JUMP  = 4'd6;
  localparam logic [OPC_W-1:0] OPC_JNEG  = 4'd7;

  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [WORD_W-1:0] wdata;
  } mem_req_t;

endpackage

`default_nettype wire

// File: rtl/acm_if.sv
// Valid/ready channel interfaces for request and response beats.
// Depends on acm_pkg.
`default_nettype none

interface acm_req_if
  import acm_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [OPER_W-1:0] operation;
  logic [ADDR_W-1:0] address;
  logic [WORD_W-1:0] write_data;

  modport source (output valid, operation, address, write_data, input ready);
  modport sink   (input valid, operation, address, write_data, output ready);
endinterface

interface acm_resp_if
  import acm_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] prog_counter;
  logic [WORD_W-1:0] accumulator;
  logic [WORD_W-1:0] operand_b;
  logic [WORD_W-1:0] instr_word;
  logic [ADDR_W-1:0] mem_addr_reg;
  logic [WORD_W-1:0] mem_data_reg;
  logic [WORD_W-1:0] alu_result;
  logic              halted;
  logic              fault;
  logic [WORD_W-1:0] read_data;

  modport source (
    output valid, prog_counter, accumulator, operand_b, instr_word, mem_addr_reg,
           mem_data_reg, alu_result, halted, fault, read_data,
    input  ready
  );
  modport sink (
    input  valid, prog_counter, accumulator, operand_b, instr_word, mem_addr_reg,
           mem_data_reg, alu_result, halted, fault, read_data,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/acm_mem.sv
// Word memory with registered read, per-word valid bits (unwritten
// words read as zero) and write-to-read forwarding. Depends on acm_pkg.
`default_nettype none

module acm_mem
  import acm_pkg::*;
#(
  parameter int MEM_WORDS = 256
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire mem_req_t          req,
  output logic      [WORD_W-1:0] rdata
);

  localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam logic [ADDR_W:0] MEM_LIMIT = (ADDR_W+1)'(MEM_WORDS);

  logic [WORD_W-1:0]    mem [MEM_WORDS];
  logic [MEM_WORDS-1:0] valid;
  logic [WORD_W-1:0]    mem_q;
  logic [WORD_W-1:0]    fwd_data;
  logic                 rd_ok;
  logic                 fwd;
  logic                 r_in;
  logic                 w_in;
  logic [AW-1:0]        ridx;
  logic [AW-1:0]        widx;

  assign r_in = {1'b0, req.raddr} < MEM_LIMIT;
  assign w_in = {1'b0, req.waddr} < MEM_LIMIT;
  assign ridx = req.raddr[AW-1:0];
  assign widx = req.waddr[AW-1:0];

  always_ff @(posedge clk) begin
    if (req.we && w_in) begin
      mem[widx] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      mem_q    <= mem[ridx];
      fwd_data <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      rd_ok <= 1'b0;
      fwd   <= 1'b0;
    end else begin
      if (req.we && w_in) begin
        valid[widx] <= 1'b1;
      end
      if (req.re) begin
        rd_ok <= r_in && valid[ridx];
        fwd   <= req.we && w_in && (req.raddr == req.waddr);
      end
    end
  end

  assign rdata = fwd ? fwd_data : (rd_ok ? mem_q : '0);

endmodule

`default_nettype wire

// File: rtl/accumulator_cpu_12bit.sv
// Top level of the 12-bit accumulator machine. Depends on acm_pkg, acm_if
// and acm_mem.
//
// Each request beat writes a memory word, reads one back, executes one
// instruction or, for an unused operation, does nothing; each gives one
// response beat with the register view after it. Memory reads are registered
// in the synchronous word memory. The fetch or read for a beat is issued in
// the cycle it is accepted; the response register is loaded in the work
// state. An executed load is the exception: it goes to the operand state
// for its operand read. The next request is taken in the cycle the current
// one finishes, so beats can follow one a cycle unless the response stalls,
// which holds the machine in its finishing state. Memory reads as zero after
// reset without any clearing pass, because each word has a written flag.
`default_nettype none

module accumulator_cpu_12bit
  import acm_pkg::*;
#(
  parameter int MEM_WORDS = 256
) (
  input  wire logic clk,
  input  wire logic rst,
  acm_req_if.sink   req,
  acm_resp_if.source resp
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WORK = 2'd1;
  localparam logic [1:0] ST_OPER = 2'd2;

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [OPER_W-1:0] op_q;
  logic [ADDR_W-1:0] addr_q;
  logic [WORD_W-1:0] wdata_q;

  logic [ADDR_W-1:0] pc, pc_next;
  logic [ADDR_W-1:0] mar, mar_next;
  logic [WORD_W-1:0] mdr, mdr_next;
  logic [WORD_W-1:0] acc, acc_next;
  logic [WORD_W-1:0] alu, alu_next;
  logic [WORD_W-1:0] breg, breg_next;
  logic [WORD_W-1:0] ir, ir_next;
  logic              halt, halt_next;
  logic              fault, fault_next;

  mem_req_t          mreq;
  logic [WORD_W-1:0] rdata;
  logic [OPC_W-1:0]  opc;
  logic [ADDR_W-1:0] tgt;
  logic              out_free;
  logic              done;
  logic              accept;

  acm_mem #(.MEM_WORDS(MEM_WORDS)) u_mem (
    .clk  (clk),
    .rst  (rst),
    .req  (mreq),
    .rdata(rdata)
  );

  assign opc      = rdata[WORD_W-1 -: OPC_W];
  assign tgt      = rdata[ADDR_W-1:0];
  assign out_free = !resp.valid || resp.ready;
  assign req.ready = !rst && ((state == ST_IDLE) || done);
  assign accept   = req.valid && req.ready;

  always_comb begin
    state_next = state;
    pc_next    = pc;
    mar_next   = mar;
    mdr_next   = mdr;
    acc_next   = acc;
    alu_next   = alu;
    breg_next  = breg;
    ir_next    = ir;
    halt_next  = halt;
    fault_next = fault;
    done       = 1'b0;
    mreq       = '0;

    case (state)
      ST_WORK: begin
        case (op_q)
          OP_WRITE: begin
            if (out_free) begin
              done       = 1'b1;
              mreq.we    = 1'b1;
              mreq.waddr = addr_q;
              mreq.wdata = wdata_q;
            end
          end
          OP_EXEC: begin
            if (halt) begin
              done = out_free;
            end else if (opc == OPC_LOAD) begin
              pc_next    = pc + 1'b1;
              ir_next    = rdata;
              mar_next   = tgt;
              mreq.re    = 1'b1;
              mreq.raddr = tgt;
              state_next = ST_OPER;
            end else if (out_free) begin
              done     = 1'b1;
              pc_next  = pc + 1'b1;
              mar_next = pc;
              mdr_next = rdata;
              ir_next  = rdata;
              case (opc)
                OPC_FAULT: begin
                  fault_next = 1'b1;
                  halt_next  = 1'b1;
                end
                OPC_STORE: begin
                  mar_next   = tgt;
                  mdr_next   = acc;
                  mreq.we    = 1'b1;
                  mreq.waddr = tgt;
                  mreq.wdata = acc;
                end
                OPC_ADD: begin
                  alu_next = acc + breg;
                  acc_next = acc + breg;
                end
                OPC_SUB: begin
                  alu_next = acc - breg;
                  acc_next = acc - breg;
                end
                OPC_COPY: begin
                  breg_next = acc;
                end
                OPC_JUMP: begin
                  pc_next = tgt;
                end
                OPC_JNEG: begin
                  if (acc[WORD_W-1]) begin
                    pc_next = tgt;
                  end
                end
                default: begin
                  halt_next = 1'b1;
                end
              endcase
            end
          end
          default: begin
            done = out_free;
          end
        endcase
      end
      ST_OPER: begin
        if (out_free) begin
          done     = 1'b1;
          mdr_next = rdata;
          acc_next = rdata;
        end
      end
      default: begin
      end
    endcase

    if (done) begin
      state_next = ST_IDLE;
    end

    // read for the new beat goes out in its accept cycle
    if (accept) begin
      state_next = ST_WORK;
      if (req.operation == OP_READ) begin
        mreq.re    = 1'b1;
        mreq.raddr = req.address;
      end else if (req.operation == OP_EXEC && !halt_next) begin
        mreq.re    = 1'b1;
        mreq.raddr = pc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pc    <= '0;
      mar   <= '0;
      mdr   <= '0;
      acc   <= '0;
      alu   <= '0;
      breg  <= '0;
      ir    <= '0;
      halt  <= 1'b0;
      fault <= 1'b0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
      mar   <= mar_next;
      mdr   <= mdr_next;
      acc   <= acc_next;
      alu   <= alu_next;
      breg  <= breg_next;
      ir    <= ir_next;
      halt  <= halt_next;
      fault <= fault_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= req.operation;
      addr_q  <= req.address;
      wdata_q <= req.write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      resp.valid <= 1'b0;
    end else if (done) begin
      resp.valid <= 1'b1;
    end else if (resp.ready) begin
      resp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      resp.prog_counter <= pc_next;
      resp.accumulator  <= acc_next;
      resp.operand_b    <= breg_next;
      resp.instr_word   <= ir_next;
      resp.mem_addr_reg <= mar_next;
      resp.mem_data_reg <= mdr_next;
      resp.alu_result   <= alu_next;
      resp.halted       <= halt_next;
      resp.fault        <= fault_next;
      resp.read_data    <= (state == ST_WORK && op_q == OP_READ) ? rdata : '0;
    end
  end

endmodule

`default_nettype wire

// File: bench/tb_accumulator_cpu_12bit.sv
// Testbench for accumulator_cpu_12bit: memory write/read beats and single-step
// execution checked field by field against a shadow copy of the machine.
// Depends on acm_pkg, acm_if (acm_req_if, acm_resp_if) and the RTL top level.
module tb_accumulator_cpu_12bit;
  timeunit 1ns;
  timeprecision 1ps;

  import acm_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam logic [OPER_W-1:0] OP_SPARE = 2'd3;
  localparam logic [OPC_W-1:0] OPC_HALT_LO = 4'd8;

  typedef struct packed {
    logic [ADDR_W-1:0] pc;
    logic [WORD_W-1:0] acc;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] ir;
    logic [ADDR_W-1:0] mar;
    logic [WORD_W-1:0] mdr;
    logic [WORD_W-1:0] alu;
    logic              halt;
    logic              fault;
    logic [WORD_W-1:0] rd;
  } reg_view_t;

  logic clk;
  logic rst;

  acm_req_if  req_ch ();
  acm_resp_if resp_ch ();

  accumulator_cpu_12bit dut (
    .clk  (clk),
    .rst  (rst),
    .req  (req_ch),
    .resp (resp_ch)
  );

  // shadow machine state
  logic [WORD_W-1:0] sh_mem [256];
  logic [ADDR_W-1:0] sh_pc;
  logic [ADDR_W-1:0] sh_mar;
  logic [WORD_W-1:0] sh_mdr;
  logic [WORD_W-1:0] sh_acc;
  logic [WORD_W-1:0] sh_alu;
  logic [WORD_W-1:0] sh_b;
  logic [WORD_W-1:0] sh_ir;
  logic              sh_halt;
  logic              sh_fault;

  reg_view_t pending_views [$];
  int        beats_sent = 0;
  int        mismatches = 0;
  int        cycle_count = 0;
  int        src_idle_pct = 0;
  int        stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic reg_view_t step_machine(input logic [OPER_W-1:0] op,
                                             input logic [ADDR_W-1:0] a,
                                             input logic [WORD_W-1:0] d);
    reg_view_t         v;
    logic [OPC_W-1:0]  opc;
    logic [ADDR_W-1:0] tgt;
    v.rd = '0;
    case (op)
      OP_WRITE: sh_mem[a] = d;
      OP_READ:  v.rd = sh_mem[a];
      OP_EXEC: begin
        if (!sh_halt) begin
          sh_mar = sh_pc;
          sh_mdr = sh_mem[sh_mar];
          sh_ir  = sh_mdr;
          sh_pc  = sh_pc + 1'b1;
          opc    = sh_ir[WORD_W-1:ADDR_W];
          tgt    = sh_ir[ADDR_W-1:0];
          case (opc)
            OPC_FAULT: begin
              sh_fault = 1'b1;
              sh_halt  = 1'b1;
            end
            OPC_LOAD: begin
              sh_mar = tgt;
              sh_mdr = sh_mem[sh_mar];
              sh_acc = sh_mdr;
            end
            OPC_STORE: begin
              sh_mar = tgt;
              sh_mdr = sh_acc;
              sh_mem[sh_mar] = sh_mdr;
            end
            OPC_ADD: begin
              sh_alu = sh_acc + sh_b;
              sh_acc = sh_alu;
            end
            OPC_SUB: begin
              sh_alu = sh_acc - sh_b;
              sh_acc = sh_alu;
            end
            OPC_COPY: sh_b = sh_acc;
            OPC_JUMP: sh_pc = tgt;
            OPC_JNEG: begin
              if (sh_acc[WORD_W-1]) sh_pc = tgt;
            end
            default: sh_halt = 1'b1;
          endcase
        end
      end
      default: ;
    endcase
    v.pc    = sh_pc;
    v.acc   = sh_acc;
    v.b     = sh_b;
    v.ir    = sh_ir;
    v.mar   = sh_mar;
    v.mdr   = sh_mdr;
    v.alu   = sh_alu;
    v.halt  = sh_halt;
    v.fault = sh_fault;
    return v;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic compare_field(input string name, input logic [WORD_W-1:0] got,
                               input logic [WORD_W-1:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  task automatic send_beat(input logic [OPER_W-1:0] op, input logic [ADDR_W-1:0] a,
                           input logic [WORD_W-1:0] d);
    while ($urandom_range(99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.operation  <= op;
    req_ch.address    <= a;
    req_ch.write_data <= d;
    do @(posedge clk); while (!req_ch.ready);
    pending_views.push_back(step_machine(op, a, d));
    beats_sent++;
  endtask

  task automatic set_idling(input int src_pct, input int snk_pct);
    src_idle_pct = src_pct;
    stall_pct    = snk_pct;
  endtask

  // one instruction; patches the word at pc first when asked or when it would halt the machine
  task automatic run_step(input bit patch);
    logic [OPC_W-1:0]  opc;
    logic [ADDR_W-1:0] tgt;
    opc = sh_mem[sh_pc][WORD_W-1:ADDR_W];
    if (patch || opc == OPC_FAULT || opc >= OPC_HALT_LO) begin
      opc = OPC_W'($urandom_range(OPC_JNEG, OPC_LOAD));
      tgt = ADDR_W'($urandom);
      send_beat(OP_WRITE, sh_pc, {opc, tgt});
    end
    send_beat(OP_EXEC, ADDR_W'($urandom), WORD_W'($urandom));
  endtask

  always @(posedge clk) resp_ch.ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    reg_view_t want;
    if (!rst && resp_ch.valid && resp_ch.ready) begin
      if (pending_views.size() == 0) begin
        report_mismatch("response beat with nothing outstanding");
      end else begin
        want = pending_views.pop_front();
        compare_field("prog_counter", WORD_W'(resp_ch.prog_counter), WORD_W'(want.pc));
        compare_field("accumulator", resp_ch.accumulator, want.acc);
        compare_field("operand_b", resp_ch.operand_b, want.b);
        compare_field("instr_word", resp_ch.instr_word, want.ir);
        compare_field("mem_addr_reg", WORD_W'(resp_ch.mem_addr_reg), WORD_W'(want.mar));
        compare_field("mem_data_reg", resp_ch.mem_data_reg, want.mdr);
        compare_field("alu_result", resp_ch.alu_result, want.alu);
        compare_field("halted", WORD_W'(resp_ch.halted), WORD_W'(want.halt));
        compare_field("fault", WORD_W'(resp_ch.fault), WORD_W'(want.fault));
        compare_field("read_data", resp_ch.read_data, want.rd);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic test_memory_access();
    send_beat(OP_WRITE, 8'd0, 12'hfff);
    send_beat(OP_READ, 8'd0, 12'h000);
    send_beat(OP_READ, 8'd77, 12'hfff);
    send_beat(OP_SPARE, 8'hff, 12'hfff);
  endtask

  // load, jneg both ways, copy, add and sub with wrap, store, jump, pc wrap at 255
  task automatic test_instruction_set();
    send_beat(OP_WRITE, 8'd200, 12'h7ff);
    send_beat(OP_WRITE, 8'd0, {OPC_LOAD, 8'd200});
    send_beat(OP_WRITE, 8'd1, {OPC_JNEG, 8'd7});
    send_beat(OP_WRITE, 8'd2, {OPC_COPY, 8'h5a});
    send_beat(OP_WRITE, 8'd3, {OPC_ADD, 8'ha5});
    send_beat(OP_WRITE, 8'd4, {OPC_JNEG, 8'd6});
    send_beat(OP_WRITE, 8'd6, {OPC_ADD, 8'd0});
    send_beat(OP_WRITE, 8'd7, {OPC_STORE, 8'd202});
    send_beat(OP_WRITE, 8'd8, {OPC_JUMP, 8'd255});
    send_beat(OP_WRITE, 8'd255, {OPC_SUB, 8'hff});
    repeat (9) send_beat(OP_EXEC, ADDR_W'($urandom), WORD_W'($urandom));
    send_beat(OP_READ, 8'd202, 12'h000);
  endtask

  task automatic random_traffic(input int count);
    int goal;
    int sel;
    goal = beats_sent + count;
    while (beats_sent < goal) begin
      sel = $urandom_range(99);
      if (sel < 50) run_step($urandom_range(99) < 35);
      else if (sel < 70) send_beat(OP_WRITE, ADDR_W'($urandom), WORD_W'($urandom));
      else if (sel < 88) send_beat(OP_READ, ADDR_W'($urandom), WORD_W'($urandom));
      else if (sel < 93) send_beat(OP_SPARE, ADDR_W'($urandom), WORD_W'($urandom));
      else run_step(1'b0);
    end
  endtask

  // halt or fault; afterwards execution is frozen but memory access still works
  task automatic test_halt();
    logic [OPC_W-1:0]  opc;
    logic [ADDR_W-1:0] a;
    logic [WORD_W-1:0] d;
    opc = $urandom_range(1) ? OPC_FAULT : OPC_W'($urandom_range(15, OPC_HALT_LO));
    a = ADDR_W'($urandom);
    send_beat(OP_WRITE, sh_pc, {opc, a});
    repeat (4) send_beat(OP_EXEC, ADDR_W'($urandom), WORD_W'($urandom));
    a = ADDR_W'($urandom);
    d = WORD_W'($urandom);
    send_beat(OP_WRITE, a, d);
    send_beat(OP_READ, a, WORD_W'($urandom));
    send_beat(OP_WRITE, sh_pc, {OPC_LOAD, a});
    repeat (2) send_beat(OP_EXEC, ADDR_W'($urandom), WORD_W'($urandom));
    send_beat(OP_SPARE, ADDR_W'($urandom), WORD_W'($urandom));
  endtask

  initial begin
    rst                <= 1'b1;
    req_ch.valid       <= 1'b0;
    req_ch.operation   <= OP_WRITE;
    req_ch.address     <= '0;
    req_ch.write_data  <= '0;
    foreach (sh_mem[i]) sh_mem[i] = '0;
    sh_pc    = '0;
    sh_mar   = '0;
    sh_mdr   = '0;
    sh_acc   = '0;
    sh_alu   = '0;
    sh_b     = '0;
    sh_ir    = '0;
    sh_halt  = 1'b0;
    sh_fault = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    set_idling(0, 0);
    test_memory_access();
    test_instruction_set();
    random_traffic(330);
    set_idling(68, 0);
    random_traffic(330);
    set_idling(0, 68);
    random_traffic(330);
    set_idling(23, 23);
    random_traffic(330);
    test_halt();

    req_ch.valid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: accumulator_cpu_12bit.f
rtl/acm_pkg.sv
rtl/acm_if.sv
rtl/acm_mem.sv
rtl/accumulator_cpu_12bit.sv
bench/tb_accumulator_cpu_12bit.sv
